>>> design/http_chunked_body_decoder_top_assert.svh
// Assertion macros for the chunked body decoder.
// Each one is checked on the rising edge of clk and is off while rst is high.
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define CHBD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define CHBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CHBD_ASSERT_SAME(label, ante, cons, msg)

`define CHBD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> design/chbd_pkg.sv
package chbd_pkg;

  localparam int SIZE_BITS = 32;

  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] body;
  } result_t;

  typedef struct packed {
    logic halted;
  } status_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

>>> design/chbd_in_reg.sv
module chbd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign s_tready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      held_byte <= s_tdata;
    end
  end

endmodule

>>> design/chbd_core.sv
module chbd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       data_byte,
  output chbd_pkg::result_t res,
  output chbd_pkg::status_t status
);

  typedef enum logic [2:0] {
    PH_DIGITS, PH_EXT, PH_LF, PH_DATA, PH_SKIP1, PH_SKIP2, PH_DONE, PH_ERROR
  } phase_t;

  phase_t                          phase, phase_next;
  logic [chbd_pkg::SIZE_BITS-1:0]  remaining, remaining_next;
  logic                            nonempty, nonempty_next;
  logic                            ended, ended_next;
  logic [4:0]                      hex;
  logic [chbd_pkg::SIZE_BITS-1:0]  dec;

  assign hex = chbd_pkg::hex_decode(data_byte);
  assign dec = remaining - {{(chbd_pkg::SIZE_BITS-1){1'b0}}, 1'b1};
  assign status.halted = (phase == PH_DONE) || (phase == PH_ERROR);

  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    nonempty_next  = nonempty;
    ended_next     = ended;
    res            = '0;
    unique case (phase)
      PH_DIGITS: begin
        if (data_byte == chbd_pkg::CH_CR) begin
          phase_next = PH_LF;
        end else if (data_byte == chbd_pkg::CH_SEMI) begin
          phase_next = PH_EXT;
        end else begin
          nonempty_next = 1'b1;
          if (!ended && hex[4]) begin
            if (remaining[chbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
              phase_next = PH_ERROR;
              res.valid  = 1'b1;
              res.kind   = chbd_pkg::KIND_ERROR;
            end else begin
              remaining_next = {remaining[chbd_pkg::SIZE_BITS-5:0], hex[3:0]};
            end
          end else begin
            ended_next = 1'b1;
          end
        end
      end
      PH_EXT: begin
        if (data_byte == chbd_pkg::CH_CR) begin
          phase_next = PH_LF;
        end
      end
      PH_LF: begin
        res.valid = 1'b1;
        if (data_byte != chbd_pkg::CH_LF || !nonempty) begin
          phase_next = PH_ERROR;
          res.kind   = chbd_pkg::KIND_ERROR;
        end else if (remaining == '0) begin
          phase_next = PH_DONE;
          res.kind   = chbd_pkg::KIND_END;
        end else begin
          phase_next = PH_DATA;
          res.valid  = 1'b0;
        end
      end
      PH_DATA: begin
        remaining_next = dec;
        if (dec == '0) begin
          phase_next = PH_SKIP1;
        end
        res.valid = 1'b1;
        res.kind  = chbd_pkg::KIND_BODY;
        res.body  = data_byte;
      end
      PH_SKIP1: phase_next = PH_SKIP2;
      PH_SKIP2: begin
        phase_next     = PH_DIGITS;
        remaining_next = '0;
        nonempty_next  = 1'b0;
        ended_next     = 1'b0;
      end
      default: ;
    endcase
    if (!fire) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DIGITS;
      remaining <= '0;
      nonempty  <= 1'b0;
      ended     <= 1'b0;
    end else if (fire) begin
      phase     <= phase_next;
      remaining <= remaining_next;
      nonempty  <= nonempty_next;
      ended     <= ended_next;
    end
  end

endmodule

>>> design/chbd_out_reg.sv
module chbd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  chbd_pkg::result_t res,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,  // body_byte
  output logic [1:0]        m_tuser   // result_kind
);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res.valid) begin
      m_tdata <= res.body;
      m_tuser <= res.kind;
    end
  end

endmodule

>>> design/http_chunked_body_decoder_top.sv
// Chunked transfer body decoder.
// Slave stream (s_*): one byte of the chunked body per transfer.
// Master stream (m_*): zero or one result per input byte. tuser holds the
// result kind (body byte, end of body, error); tdata holds the body byte,
// zero for end and error results.
// A byte accepted into the input register is decoded, and its result, if
// any, is registered in the output register once that slot is free.
// Throughput: one byte per cycle while the receiver does not stall; the size
// line, data count and skip bytes are all decoded by one state update per byte.
// Extensions and the two bytes after each chunk give no result; a size line
// gives only an end or error result, and after one all further bytes are
// dropped until reset. Reset (rst, synchronous) clears both registers and
// returns the decoder to the start of a size line.
// If the receiver stalls, the held result stays on m_*; one more byte is
// held in the input register, then s_tready drops.
`include "http_chunked_body_decoder_top_assert.svh"

module http_chunked_body_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] body_byte
  output logic [1:0] m_tuser    // [1:0] result_kind
);

  logic              held_valid;
  logic [7:0]        held_byte;
  logic              fire;
  chbd_pkg::result_t res;
  chbd_pkg::status_t status;

  // decode only when the output slot is free or being drained
  assign fire = held_valid && (!m_tvalid || m_tready);

  chbd_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .advance    (fire),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  chbd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (held_byte),
    .res       (res),
    .status    (status)
  );

  chbd_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  `CHBD_ASSERT_NEXT(a_halt_sticky, status.halted, status.halted, "decoder left halt without reset")
  `CHBD_ASSERT_SAME(a_halt_quiet, status.halted, !res.valid, "result produced after end or error")
  `CHBD_ASSERT_SAME(a_ctl_body_zero, m_tvalid && m_tuser != chbd_pkg::KIND_BODY, m_tdata == 8'd0, "end or error result carries data")
  `CHBD_ASSERT_SAME(a_kind_range, m_tvalid, m_tuser == chbd_pkg::KIND_BODY || m_tuser == chbd_pkg::KIND_END || m_tuser == chbd_pkg::KIND_ERROR, "undefined result kind")

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int QUIET_LIMIT = 2000;   // longest legal silence is the long receiver hold
  localparam int RX_HOLD     = 400;

  typedef enum logic [2:0] {
    LINE_DIGITS, LINE_EXT, LINE_LF, CHUNK_DATA, TRAIL_A, TRAIL_B, BODY_DONE, BODY_BROKEN
  } phase_t;

  typedef enum {
    CLOSE_ZERO_SIZE, CLOSE_NO_DIGITS, CLOSE_EMPTY_LINE, CLOSE_BARE_CR, CLOSE_OVERFLOW
  } close_t;

  typedef struct {
    chbd_pkg::kind_t kind;
    logic [7:0]      body;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] data_byte
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] body_byte
  logic [1:0] m_tuser;           // [1:0] result_kind

  http_chunked_body_decoder_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // decoder shadow state
  phase_t                         phase = LINE_DIGITS;
  logic [chbd_pkg::SIZE_BITS-1:0] chunk_left = '0;
  bit                             line_has_text;
  bit                             digits_closed;

  decoded_t awaited_results[$];

  bit     gaps_on = 1'b1;
  int     rx_hold_req;
  int     rx_hold_left;
  int     quiet_cycles;
  int     fail_count;
  int     bytes_sent;
  int     bytes_accepted;
  int     chunks_sent;
  int     results_seen;
  int     body_seen;
  close_t close_kind;

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void decode_byte(logic [7:0] c);
    int nib;
    nib = hex_nibble(c);
    case (phase)
      LINE_DIGITS: begin
        if (c == chbd_pkg::CH_CR) begin
          phase = LINE_LF;
        end else if (c == chbd_pkg::CH_SEMI) begin
          phase = LINE_EXT;
        end else begin
          line_has_text = 1'b1;
          if (!digits_closed && nib >= 0) begin
            if (chunk_left[chbd_pkg::SIZE_BITS-1 -: 4] != 4'h0) begin
              phase = BODY_BROKEN;
              awaited_results.push_back('{chbd_pkg::KIND_ERROR, 8'h00});
            end else begin
              chunk_left = {chunk_left[chbd_pkg::SIZE_BITS-5:0], 4'(nib)};
            end
          end else begin
            digits_closed = 1'b1;
          end
        end
      end
      LINE_EXT: begin
        if (c == chbd_pkg::CH_CR) phase = LINE_LF;
      end
      LINE_LF: begin
        if (c != chbd_pkg::CH_LF || !line_has_text) begin
          phase = BODY_BROKEN;
          awaited_results.push_back('{chbd_pkg::KIND_ERROR, 8'h00});
        end else if (chunk_left == '0) begin
          phase = BODY_DONE;
          awaited_results.push_back('{chbd_pkg::KIND_END, 8'h00});
        end else begin
          phase = CHUNK_DATA;
        end
      end
      CHUNK_DATA: begin
        chunk_left = chunk_left - {{(chbd_pkg::SIZE_BITS-1){1'b0}}, 1'b1};
        if (chunk_left == '0) phase = TRAIL_A;
        awaited_results.push_back('{chbd_pkg::KIND_BODY, c});
      end
      TRAIL_A: begin
        phase = TRAIL_B;
      end
      TRAIL_B: begin
        phase         = LINE_DIGITS;
        chunk_left    = '0;
        line_has_text = 1'b0;
        digits_closed = 1'b0;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      bytes_accepted++;
      decode_byte(s_tdata);
    end
  end

  always @(posedge clk) begin
    decoded_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: result_kind %0d body_byte 0x%02h", m_tuser, m_tdata);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (want.kind == chbd_pkg::KIND_BODY) body_seen++;
        if (m_tuser !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, m_tuser);
          fail_count++;
        end
        if (m_tdata !== want.body) begin
          $error("body_byte: expected 0x%02h, got 0x%02h", want.body, m_tdata);
          fail_count++;
        end
      end
    end
  end

  // receiver: random idling, or a long hold requested by a test
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      m_tready     <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_req > 0) begin
      m_tready     <= 1'b0;
      rx_hold_left <= rx_hold_req - 1;
      rx_hold_req = 0;
    end else begin
      m_tready <= !(gaps_on && $urandom_range(99) < 18);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("no transfer for %0d cycles", QUIET_LIMIT);
      $display("[http_chunked_body_decoder_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(logic [7:0] b);
    while (gaps_on && $urandom_range(99) < 18) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_crlf();
    send_byte(chbd_pkg::CH_CR);
    send_byte(chbd_pkg::CH_LF);
  endtask

  // never CR; optionally never hex or ';'
  function automatic logic [7:0] pick_byte(bit no_hex, bit no_semi);
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == chbd_pkg::CH_CR || (no_semi && b == chbd_pkg::CH_SEMI) ||
           (no_hex && hex_nibble(b) >= 0));
    return b;
  endfunction

  function automatic logic [7:0] hex_char(int v);
    logic [7:0] c;
    c = (v < 10) ? 8'(8'h30 + v) : 8'(8'h61 + v - 10);
    if (v >= 10 && $urandom_range(1)) c = c - 8'h20;
    return c;
  endfunction

  function automatic int unsigned chunk_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(8, 1);
    if (r < 95) return $urandom_range(40, 9);
    return $urandom_range(300, 41);
  endfunction

  task automatic send_chunk(int unsigned size);
    string       digits;
    int unsigned zeros;
    zeros = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(1);
    repeat (zeros) send_byte("0");
    digits = $sformatf("%0h", size);
    foreach (digits[i]) send_byte(hex_char(hex_nibble(digits[i])));
    if ($urandom_range(5) == 0) begin
      // first junk byte must end the digits, the rest may be anything but ';' or CR
      send_byte(pick_byte(1'b1, 1'b1));
      repeat ($urandom_range(3)) send_byte(pick_byte(1'b0, 1'b1));
    end
    if ($urandom_range(3) == 0) begin
      send_byte(chbd_pkg::CH_SEMI);
      repeat ($urandom_range(6)) send_byte(pick_byte(1'b0, 1'b0));
    end
    send_crlf();
    repeat (size) send_byte(8'($urandom_range(255)));
    if ($urandom_range(4) == 0) begin
      send_byte(8'($urandom_range(255)));
      send_byte(8'($urandom_range(255)));
    end else begin
      send_crlf();
    end
    chunks_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat ($urandom_range(6, 1)) @(posedge clk);
  endtask

  task automatic test_directed();
    // size 01 with an extension holding 0xFF and a stray LF
    send_byte("0");
    send_byte("1");
    send_byte(chbd_pkg::CH_SEMI);
    send_byte(8'hFF);
    send_byte(chbd_pkg::CH_LF);
    send_crlf();
    send_byte(8'h00);
    send_crlf();
    // size 2, junk after the digits, then a trailer that is not CR LF
    send_byte("2");
    send_byte("g");
    send_byte("5");
    send_crlf();
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_random_chunks(int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      send_chunk(chunk_size());
      if ($urandom_range(39) == 0) wait_drained();
    end
  endtask

  task automatic test_no_gaps();
    int stop_at;
    gaps_on = 1'b0;
    stop_at = bytes_sent + 200;
    while (bytes_sent < stop_at) send_chunk(chunk_size());
    gaps_on = 1'b1;
  endtask

  task automatic test_rx_hold();
    rx_hold_req = RX_HOLD;
    send_chunk(48);
    send_chunk(chunk_size());
  endtask

  task automatic test_drain_pause();
    send_chunk(chunk_size());
    wait_drained();
    send_chunk(chunk_size());
  endtask

  task automatic test_close_stream();
    close_kind = close_t'($urandom_range(4));
    case (close_kind)
      CLOSE_ZERO_SIZE: begin
        send_byte("0");
        repeat ($urandom_range(3)) send_byte("0");
        if ($urandom_range(1)) begin
          send_byte(chbd_pkg::CH_SEMI);
          repeat ($urandom_range(4)) send_byte(pick_byte(1'b0, 1'b0));
        end
        send_crlf();
      end
      CLOSE_NO_DIGITS: begin
        send_byte(pick_byte(1'b1, 1'b1));
        repeat ($urandom_range(3)) send_byte(pick_byte(1'b0, 1'b1));
        send_crlf();
      end
      CLOSE_EMPTY_LINE: begin
        if ($urandom_range(1)) begin
          send_byte(chbd_pkg::CH_SEMI);
          repeat ($urandom_range(3)) send_byte(pick_byte(1'b0, 1'b0));
        end
        send_crlf();
      end
      CLOSE_BARE_CR: begin
        send_byte(hex_char($urandom_range(15, 1)));
        if ($urandom_range(1)) send_byte(chbd_pkg::CH_SEMI);
        send_byte(chbd_pkg::CH_CR);
        send_byte(chbd_pkg::CH_LF ^ 8'($urandom_range(255, 1)));
      end
      CLOSE_OVERFLOW: begin
        send_byte(hex_char($urandom_range(15, 1)));
        repeat (8) send_byte(hex_char($urandom_range(15)));
      end
      default: ;
    endcase
    // everything after the close is dropped
    repeat (10) send_byte(8'($urandom_range(255)));
    s_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_chunks(700);
    test_no_gaps();
    test_rx_hold();
    test_drain_pause();
    test_random_chunks(500);
    test_close_stream();
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d bytes in %0d chunks, %0d results checked (%0d body bytes)",
             bytes_accepted, chunks_sent, results_seen, body_seen);
    $display("stream closed by %s after a long receiver hold and a full drain pause",
             close_kind.name());
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("[http_chunked_body_decoder_top] OK");
    end else begin
      $display("[http_chunked_body_decoder_top] ERROR");
    end
    $finish;
  end

endmodule
